FILE: design/matrix3_inverse_macros.svh
// assertion helpers for the matrix inverse block
`ifndef MATRIX3_INVERSE_MACROS_SVH
`define MATRIX3_INVERSE_MACROS_SVH

// same-cycle implication, reset-qualified
`define M3I_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, reset-qualified
`define M3I_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/m3i_pkg.sv
`default_nettype none
package m3i_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int WORD_BITS_DEF = 32;
    localparam int N_ENT         = 9;
    localparam int EPS_W         = 31;
    localparam logic [EPS_W-1:0] EPS_RESET = 31'd1;

    // cofactor k = m[A]*m[B] - m[C]*m[D]
    localparam int COF_A [N_ENT] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
    localparam int COF_B [N_ENT] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
    localparam int COF_C [N_ENT] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
    localparam int COF_D [N_ENT] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

    // flags that ride alongside the division pipeline
    typedef struct packed {
        logic [N_ENT-1:0] neg;
        logic [N_ENT-1:0] ovf;
        logic             singular;
    } m3i_side_t;

endpackage
`default_nettype wire

FILE: design/m3i_divider.sv
`default_nettype none
module m3i_divider #(
    parameter int WORD_BITS = m3i_pkg::WORD_BITS_DEF,
    parameter int DW        = 3 * m3i_pkg::WORD_BITS_DEF + 2,
    parameter int RW        = DW + 1
) (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     in_valid,
    output logic                    in_ready,
    input  wire  [RW-1:0]           rem_in [m3i_pkg::N_ENT],
    input  wire  [WORD_BITS-1:0]    low_in [m3i_pkg::N_ENT],
    input  wire  [DW-1:0]           den_in,
    input  m3i_pkg::m3i_side_t      side_in,
    output logic                    out_valid,
    input  wire                     out_ready,
    output logic [WORD_BITS-1:0]    quo_out [m3i_pkg::N_ENT],
    output m3i_pkg::m3i_side_t      side_out
);

    localparam int NE = m3i_pkg::N_ENT;

    logic [RW-1:0]        r_st    [WORD_BITS+1][NE];
    logic [WORD_BITS-1:0] low_st  [WORD_BITS+1][NE];
    logic [WORD_BITS-1:0] q_st    [WORD_BITS+1][NE];
    logic [DW-1:0]        d_st    [WORD_BITS+1];
    m3i_pkg::m3i_side_t   side_st [WORD_BITS+1];
    logic                 v_st    [WORD_BITS+1];
    logic                 rdy     [WORD_BITS+2];

    always_comb
    begin
        for (int i = 0; i < NE; i++)
        begin
            r_st[0][i]   = rem_in[i];
            low_st[0][i] = low_in[i];
            q_st[0][i]   = '0;
        end
        d_st[0]    = den_in;
        side_st[0] = side_in;
        v_st[0]    = in_valid;
    end

    assign rdy[WORD_BITS+1] = out_ready;
    assign in_ready         = rdy[1];

    genvar s;
    generate
        for (s = 0; s < WORD_BITS; s++)
        begin : g_step
            logic [RW-1:0]        r_next   [NE];
            logic [WORD_BITS-1:0] q_next   [NE];
            logic [RW:0]          diff;
            logic [RW-1:0]        r_sh;
            logic                 v_reg;

            assign rdy[s+1] = !v_reg || rdy[s+2];

            // one restoring step per lane
            always_comb
            begin
                diff = '0;
                r_sh = '0;
                for (int i = 0; i < NE; i++)
                begin
                    r_sh = {r_st[s][i][RW-2:0], low_st[s][i][WORD_BITS-1]};
                    diff = {1'b0, r_sh} - {2'b0, d_st[s]};
                    r_next[i] = diff[RW] ? r_sh : diff[RW-1:0];
                    q_next[i] = {q_st[s][i][WORD_BITS-2:0], !diff[RW]};
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg <= 1'b0;
                end
                else if (rdy[s+1])
                begin
                    v_reg <= v_st[s];
                end
            end

            always_ff @(posedge clk)
            begin
                if (rdy[s+1] && v_st[s])
                begin
                    for (int i = 0; i < NE; i++)
                    begin
                        r_st[s+1][i]   <= r_next[i];
                        q_st[s+1][i]   <= q_next[i];
                        low_st[s+1][i] <= {low_st[s][i][WORD_BITS-2:0], 1'b0};
                    end
                    d_st[s+1]    <= d_st[s];
                    side_st[s+1] <= side_st[s];
                end
            end

            assign v_st[s+1] = v_reg;
        end
    endgenerate

    assign out_valid = v_st[WORD_BITS];
    assign side_out  = side_st[WORD_BITS];
    always_comb
    begin
        for (int i = 0; i < NE; i++)
        begin
            quo_out[i] = q_st[WORD_BITS][i];
        end
    end

endmodule
`default_nettype wire

FILE: design/matrix3_inverse.sv
// channel  | handshake                 | payload
// ---------+---------------------------+------------------------------------------
// input    | in_valid / in_stall       | m00 .. m22, signed Q16.16
// output   | out_valid / out_stall     | inv00 .. inv22, invertible, saturated
// config   | cfg_valid / cfg_ready     | cfg_data: det_epsilon, unsigned Q15.16
//
// one matrix per cycle sustained while out_stall is low; seven arithmetic stages,
// one divider stage per quotient bit and an output register
// every stage holds its own valid bit, so bubbles collapse under a stall
// rst_n clears valid bits and sets det_epsilon to 1 LSB; no clearing pass
// cfg_ready is always high
`default_nettype none
`include "matrix3_inverse_macros.svh"
module matrix3_inverse #(
    parameter int FRAC_BITS = m3i_pkg::FRAC_BITS_DEF,
    parameter int WORD_BITS = m3i_pkg::WORD_BITS_DEF
) (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           cfg_valid,
    output logic                          cfg_ready,
    input  wire  [m3i_pkg::EPS_W-1:0]     cfg_data,
    input  wire                           in_valid,
    output logic                          in_stall,
    input  wire  signed [WORD_BITS-1:0]   m00,
    input  wire  signed [WORD_BITS-1:0]   m01,
    input  wire  signed [WORD_BITS-1:0]   m02,
    input  wire  signed [WORD_BITS-1:0]   m10,
    input  wire  signed [WORD_BITS-1:0]   m11,
    input  wire  signed [WORD_BITS-1:0]   m12,
    input  wire  signed [WORD_BITS-1:0]   m20,
    input  wire  signed [WORD_BITS-1:0]   m21,
    input  wire  signed [WORD_BITS-1:0]   m22,
    output logic                          out_valid,
    input  wire                           out_stall,
    output logic signed [WORD_BITS-1:0]   inv00,
    output logic signed [WORD_BITS-1:0]   inv01,
    output logic signed [WORD_BITS-1:0]   inv02,
    output logic signed [WORD_BITS-1:0]   inv10,
    output logic signed [WORD_BITS-1:0]   inv11,
    output logic signed [WORD_BITS-1:0]   inv12,
    output logic signed [WORD_BITS-1:0]   inv20,
    output logic signed [WORD_BITS-1:0]   inv21,
    output logic signed [WORD_BITS-1:0]   inv22,
    output logic                          invertible,
    output logic                          saturated
);

    localparam int W     = WORD_BITS;
    localparam int NE    = m3i_pkg::N_ENT;
    localparam int EW    = m3i_pkg::EPS_W;
    localparam int PW    = 2 * W;            // entry product
    localparam int AW    = 2 * W + 1;        // cofactor
    localparam int HW    = 2 * W + 1;        // det partial product
    localparam int DW    = 3 * W + 2;        // determinant
    localparam int NW    = AW + 2 * FRAC_BITS; // scaled numerator
    localparam int RW    = DW + 1;           // division remainder
    localparam int CW    = NW + DW;          // overflow compare width
    localparam int SW    = DW + EW + 2 * FRAC_BITS; // threshold compare width

    // epsilon register
    logic [EW-1:0] eps_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eps_reg <= m3i_pkg::EPS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            eps_reg <= cfg_data;
        end
    end

    // stage valid bits and the ready chain
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy7;
    logic div_in_ready, div_out_valid, div_out_ready;
    logic out_valid_reg;

    assign rdy7 = !v7_reg || div_in_ready;
    assign rdy6 = !v6_reg || rdy7;
    assign rdy5 = !v5_reg || rdy6;
    assign rdy4 = !v4_reg || rdy5;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign in_stall = !rdy1;
    assign div_out_ready = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) v1_reg <= in_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
            if (rdy5) v5_reg <= v4_reg;
            if (rdy6) v6_reg <= v5_reg;
            if (rdy7) v7_reg <= v6_reg;
        end
    end

    logic signed [W-1:0] m_in [NE];
    assign m_in[0] = m00;
    assign m_in[1] = m01;
    assign m_in[2] = m02;
    assign m_in[3] = m10;
    assign m_in[4] = m11;
    assign m_in[5] = m12;
    assign m_in[6] = m20;
    assign m_in[7] = m21;
    assign m_in[8] = m22;

    // stage 1: the eighteen entry products
    logic signed [PW-1:0] pab_reg [NE];
    logic signed [PW-1:0] pcd_reg [NE];
    logic signed [W-1:0]  row1_reg [3];
    // stage 2: cofactors
    logic signed [AW-1:0] adj2_reg [NE];
    logic signed [W-1:0]  row2_reg [3];
    // stage 3: determinant partial products, adjugate split in low and high halves
    logic signed [HW-1:0] plo_reg [3];
    logic signed [HW-1:0] phi_reg [3];
    logic signed [AW-1:0] adj3_reg [NE];
    // stage 4: per-term sums
    logic signed [DW-1:0] term_reg [3];
    logic signed [AW-1:0] adj4_reg [NE];
    // stage 5: determinant
    logic signed [DW-1:0] det_reg;
    logic signed [AW-1:0] adj5_reg [NE];
    // stage 6: magnitudes and signs
    logic [DW-1:0]        absd6_reg;
    logic [AW-1:0]        absa6_reg [NE];
    logic [NE-1:0]        neg6_reg;
    // stage 7: threshold, overflow and first remainder
    logic [DW-1:0]        absd7_reg;
    logic [RW-1:0]        rem7_reg [NE];
    logic [W-1:0]         low7_reg [NE];
    m3i_pkg::m3i_side_t   side7_reg;

    genvar g;
    generate
        for (g = 0; g < NE; g++)
        begin : g_prod
            always_ff @(posedge clk)
            begin
                if (rdy1 && in_valid)
                begin
                    pab_reg[g] <= m_in[m3i_pkg::COF_A[g]] * m_in[m3i_pkg::COF_B[g]];
                    pcd_reg[g] <= m_in[m3i_pkg::COF_C[g]] * m_in[m3i_pkg::COF_D[g]];
                end
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (rdy1 && in_valid)
        begin
            for (int j = 0; j < 3; j++)
            begin
                row1_reg[j] <= m_in[j];
            end
        end
        if (rdy2 && v1_reg)
        begin
            for (int i = 0; i < NE; i++)
            begin
                adj2_reg[i] <= {pab_reg[i][PW-1], pab_reg[i]} - {pcd_reg[i][PW-1], pcd_reg[i]};
            end
            row2_reg <= row1_reg;
        end
        if (rdy3 && v2_reg)
        begin
            // row 0 entries meet cofactors 0, 3 and 6
            for (int j = 0; j < 3; j++)
            begin
                plo_reg[j] <= row2_reg[j] * $signed({1'b0, adj2_reg[3*j][W-1:0]});
                phi_reg[j] <= row2_reg[j] * $signed(adj2_reg[3*j][AW-1:W]);
            end
            adj3_reg <= adj2_reg;
        end
        if (rdy4 && v3_reg)
        begin
            for (int j = 0; j < 3; j++)
            begin
                term_reg[j] <= $signed({phi_reg[j][HW-1], phi_reg[j], {W{1'b0}}})
                             + $signed({{(DW-HW){plo_reg[j][HW-1]}}, plo_reg[j]});
            end
            adj4_reg <= adj3_reg;
        end
        if (rdy5 && v4_reg)
        begin
            det_reg  <= term_reg[0] + term_reg[1] + term_reg[2];
            adj5_reg <= adj4_reg;
        end
        if (rdy6 && v5_reg)
        begin
            absd6_reg <= det_reg[DW-1] ? DW'(-det_reg) : DW'(det_reg);
            for (int i = 0; i < NE; i++)
            begin
                absa6_reg[i] <= adj5_reg[i][AW-1] ? AW'(-adj5_reg[i]) : AW'(adj5_reg[i]);
                neg6_reg[i]  <= adj5_reg[i][AW-1] ^ det_reg[DW-1];
            end
        end
    end

    // stage 7 logic
    logic [NW-1:0]    num7     [NE];
    logic [NW-W-1:0]  top7     [NE];
    logic [NW-W+RW-1:0] topx7  [NE];
    logic [NE-1:0]    ovf7;
    logic             sing7;

    always_comb
    begin
        // |det| <= eps scaled up by 2^(2*frac)
        sing7 = ({{(SW-DW){1'b0}}, absd6_reg}
              <= {{(SW-EW-2*FRAC_BITS){1'b0}}, eps_reg, {(2*FRAC_BITS){1'b0}}});
        for (int i = 0; i < NE; i++)
        begin
            num7[i]  = {absa6_reg[i], {(2*FRAC_BITS){1'b0}}};
            top7[i]  = num7[i][NW-1:W];
            topx7[i] = {{RW{1'b0}}, top7[i]};
            // quotient reaches 2^W exactly when the upper part is not below the divisor
            ovf7[i]  = ({{(CW-NW+W){1'b0}}, top7[i]} >= {{(CW-DW){1'b0}}, absd6_reg});
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy7 && v6_reg)
        begin
            absd7_reg <= absd6_reg;
            for (int i = 0; i < NE; i++)
            begin
                rem7_reg[i] <= topx7[i][RW-1:0];
                low7_reg[i] <= num7[i][W-1:0];
            end
            side7_reg.neg      <= neg6_reg;
            side7_reg.ovf      <= ovf7;
            side7_reg.singular <= sing7;
        end
    end

    // one quotient bit per stage
    logic [W-1:0]       quo   [NE];
    m3i_pkg::m3i_side_t side_q;

    m3i_divider #(
        .WORD_BITS (W),
        .DW        (DW),
        .RW        (RW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v7_reg),
        .in_ready  (div_in_ready),
        .rem_in    (rem7_reg),
        .low_in    (low7_reg),
        .den_in    (absd7_reg),
        .side_in   (side7_reg),
        .out_valid (div_out_valid),
        .out_ready (div_out_ready),
        .quo_out   (quo),
        .side_out  (side_q)
    );

    // sign, saturation and singular clearing
    logic [W-1:0] inv_next [NE];
    logic [NE-1:0] sat_lane;
    logic [W-1:0] inv_reg [NE];
    logic         invertible_reg;
    logic         saturated_reg;

    always_comb
    begin
        for (int i = 0; i < NE; i++)
        begin
            if (side_q.neg[i])
            begin
                sat_lane[i] = side_q.ovf[i] || (quo[i][W-1] && (|quo[i][W-2:0]));
                inv_next[i] = sat_lane[i] ? {1'b1, {(W-1){1'b0}}} : W'(-quo[i]);
            end
            else
            begin
                sat_lane[i] = side_q.ovf[i] || quo[i][W-1];
                inv_next[i] = sat_lane[i] ? {1'b0, {(W-1){1'b1}}} : quo[i];
            end
            if (side_q.singular)
            begin
                inv_next[i] = '0;
                sat_lane[i] = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (div_out_ready)
        begin
            out_valid_reg <= div_out_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (div_out_ready && div_out_valid)
        begin
            inv_reg        <= inv_next;
            invertible_reg <= !side_q.singular;
            saturated_reg  <= |sat_lane;
        end
    end

    assign out_valid  = out_valid_reg;
    assign inv00      = inv_reg[0];
    assign inv01      = inv_reg[1];
    assign inv02      = inv_reg[2];
    assign inv10      = inv_reg[3];
    assign inv11      = inv_reg[4];
    assign inv12      = inv_reg[5];
    assign inv20      = inv_reg[6];
    assign inv21      = inv_reg[7];
    assign inv22      = inv_reg[8];
    assign invertible = invertible_reg;
    assign saturated  = saturated_reg;

    // input backs up only when the whole pipe is full behind a stalled output
    `M3I_ASSERT_NOW(a_stall_full, clk, rst_n, in_stall, out_valid && out_stall, "input stalled with room in the pipe")
    // a singular result carries no saturation
    `M3I_ASSERT_NOW(a_sing_nosat, clk, rst_n, out_valid && !invertible, !saturated, "saturation on singular matrix")
    // a singular result is all zero; the diagonal entries are checked
    `M3I_ASSERT_NOW(a_sing_zero, clk, rst_n, out_valid && !invertible, inv00 == 0 && inv11 == 0 && inv22 == 0, "nonzero entry on singular matrix")

endmodule
`default_nettype wire
